### rtl/sitbd_pkg.sv
// ----------------------------------------------------------------------------
// sitbd_pkg: shared types and constants for the radix text converter
// Character codes, register indexes, reset values and the configuration
// bundle handed from the register block to the datapath.
// ----------------------------------------------------------------------------
package sitbd_pkg;

  // largest radix the alphabet can describe
  localparam int MAX_BASE = 16;

  // characters with a special meaning
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;

  // configuration register indexes
  localparam logic [1:0] REG_BASE_SIZE = 2'd0;
  localparam logic [1:0] REG_ALPHA_LO  = 2'd1;
  localparam logic [1:0] REG_ALPHA_HI  = 2'd2;

  // reset values: decimal digits "0123456789"
  localparam logic [4:0]  RST_BASE_SIZE = 5'd10;
  localparam logic [63:0] RST_ALPHA_LO  = 64'h3736_3534_3332_3130;
  localparam logic [63:0] RST_ALPHA_HI  = 64'h0000_0000_0000_3938;

  // configuration view seen by the datapath
  typedef struct packed {
    logic [4:0]   base_size;  // radix
    logic [127:0] alphabet;   // digit 0 in the low byte
    logic         ok;         // alphabet usable
    logic         busy;       // write in flight, validity not yet settled
  } cfg_t;

endpackage

### rtl/sitbd_cfg.sv
// ----------------------------------------------------------------------------
// sitbd_cfg: configuration registers and alphabet check
// Holds radix and alphabet, and registers whether the alphabet is usable.
// ----------------------------------------------------------------------------
module sitbd_cfg
  import sitbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [63:0] cfg_wdata,
  output cfg_t        cfg
);

  logic [4:0]  base_size_r;
  logic [63:0] alpha_lo_r;
  logic [63:0] alpha_hi_r;
  logic        ok_r;
  logic        pend_r;
  logic        ok_nxt;

  // radix in range, no zero/plus/minus byte, no repeated character
  function automatic logic alpha_valid(input logic [4:0] n, input logic [127:0] a);
    logic       ok;
    logic [7:0] ci;
    ok = (n >= 5'd2) && (n <= 5'(MAX_BASE));
    for (int i = 0; i < 16; i++) begin
      ci = a[i*8 +: 8];
      if (5'(i) < n) begin
        if (ci == 8'h00 || ci == CHAR_PLUS || ci == CHAR_MINUS) begin
          ok = 1'b0;
        end
        for (int j = i + 1; j < 16; j++) begin
          if (5'(j) < n && a[j*8 +: 8] == ci) begin
            ok = 1'b0;
          end
        end
      end
    end
    return ok;
  endfunction

  // check the stored alphabet
  always_comb begin
    ok_nxt = alpha_valid(base_size_r, {alpha_hi_r, alpha_lo_r});
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_size_r <= RST_BASE_SIZE;
      alpha_lo_r  <= RST_ALPHA_LO;
      alpha_hi_r  <= RST_ALPHA_HI;
      ok_r        <= 1'b1;
      pend_r      <= 1'b0;
    end else begin
      pend_r <= cfg_we;
      ok_r   <= ok_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_BASE_SIZE: base_size_r <= cfg_wdata[4:0];
          REG_ALPHA_LO:  alpha_lo_r  <= cfg_wdata;
          REG_ALPHA_HI:  alpha_hi_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // hold off intake until the check has seen the new values
  assign cfg.base_size = base_size_r;
  assign cfg.alphabet  = {alpha_hi_r, alpha_lo_r};
  assign cfg.ok        = ok_r;
  assign cfg.busy      = cfg_we | pend_r;

endmodule

### rtl/sitbd_front.sv
// ----------------------------------------------------------------------------
// sitbd_front: intake and classification
// Accepts a value, drops it under an unusable alphabet, and otherwise
// splits it into sign and unsigned magnitude for the queue.
// ----------------------------------------------------------------------------
module sitbd_front
  import sitbd_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  input  cfg_t                  cfg,
  output logic                  push_valid,
  input  logic                  push_ready,
  output logic [VALUE_BITS:0]   push_data
);

  logic                  neg;
  logic [VALUE_BITS-1:0] mag;

  // take a beat only with queue room and a settled configuration
  assign in_ready = push_ready & ~cfg.busy;

  // sign and magnitude; the most negative value wraps to its unsigned size
  assign neg = in_value[VALUE_BITS-1];
  assign mag = neg ? (~in_value + 1'b1) : in_value;

  // push only when the alphabet is usable
  assign push_valid = in_valid & ~cfg.busy & cfg.ok;
  assign push_data  = {neg, mag};

endmodule

### rtl/sitbd_fifo.sv
// ----------------------------------------------------------------------------
// sitbd_fifo: two-entry queue between intake and conversion
// ----------------------------------------------------------------------------
module sitbd_fifo #(
  parameter int WIDTH = 33
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             push;
  logic             pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

### rtl/sitbd_back.sv
// ----------------------------------------------------------------------------
// sitbd_back: digit generation and character drain
// Divides the magnitude by the radix eight quotient bits a cycle, stores
// the remainders, then sends the sign and the digits most significant first.
// ----------------------------------------------------------------------------
module sitbd_back
  import sitbd_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic [VALUE_BITS:0]   q_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_char,
  output logic                  out_last
);

  localparam int CHUNKS   = (VALUE_BITS + 7) / 8;
  localparam int PAD_BITS = CHUNKS * 8;
  localparam int CH_W     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int IDX_W    = $clog2(VALUE_BITS);
  localparam int CNT_W    = $clog2(VALUE_BITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_RD,
    ST_EMIT
  } state_t;

  state_t              state_r,  state_nxt;
  logic [PAD_BITS-1:0] w_r,      w_nxt;
  logic [3:0]          rem_r,    rem_nxt;
  logic [CH_W-1:0]     chunk_r,  chunk_nxt;
  logic [CNT_W-1:0]    cnt_r,    cnt_nxt;
  logic                neg_r,    neg_nxt;
  logic                none_r,   none_nxt;
  logic [IDX_W-1:0]    idx_r,    idx_nxt;
  logic                oval_r,   oval_nxt;
  logic [7:0]          ochar_r,  ochar_nxt;
  logic                olast_r,  olast_nxt;

  logic [3:0]          store_mem [VALUE_BITS];
  logic [3:0]          rdata_r;
  logic                mem_we;

  logic [11:0]         step;
  logic [PAD_BITS+7:0] cat;
  logic [PAD_BITS-1:0] w_sh;
  logic [CNT_W-1:0]    cnt_inc;
  logic [6:0]          cnt_w7;
  logic [5:0]          cnt6;
  logic                slot_free;

  // eight restoring steps of long division by the radix: {remainder, quotient}
  function automatic logic [11:0] div_byte(input logic [3:0] r_in, input logic [7:0] b,
                                           input logic [4:0] d);
    logic [3:0] r;
    logic [4:0] t;
    logic [7:0] q;
    r = r_in;
    q = 8'h00;
    for (int k = 7; k >= 0; k--) begin
      t = {r, b[k]};
      if (t >= d) begin
        t    = t - d;
        q[k] = 1'b1;
      end
      r = t[3:0];
    end
    return {r, q};
  endfunction

  // digit value to alphabet character
  function automatic logic [7:0] alpha_char(input logic [127:0] a, input logic [3:0] dg);
    return a[{dg, 3'b000} +: 8];
  endfunction

  assign step      = div_byte(rem_r, w_r[PAD_BITS-1 -: 8], cfg.base_size);
  assign cat       = {w_r, step[7:0]};
  assign w_sh      = cat[PAD_BITS-1:0];
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign cnt_w7    = 7'(cnt_inc);
  assign cnt6      = cnt_w7[5:0];
  assign slot_free = ~oval_r | out_ready;
  assign q_ready   = (state_r == ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    w_nxt     = w_r;
    rem_nxt   = rem_r;
    chunk_nxt = chunk_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    none_nxt  = none_r;
    idx_nxt   = idx_r;
    oval_nxt  = oval_r & ~out_ready;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;
    mem_we    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          w_nxt     = PAD_BITS'(q_data[VALUE_BITS-1:0]);
          neg_nxt   = q_data[VALUE_BITS];
          rem_nxt   = 4'd0;
          chunk_nxt = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        w_nxt = w_sh;
        if (chunk_r == CH_W'(CHUNKS - 1)) begin
          // one digit finished: store remainder, restart on the quotient
          mem_we    = 1'b1;
          cnt_nxt   = cnt_inc;
          rem_nxt   = 4'd0;
          chunk_nxt = '0;
          if (w_sh == '0 || cnt_inc == CNT_W'(VALUE_BITS)) begin
            idx_nxt  = IDX_W'(cnt6 - 6'd1);
            none_nxt = (cnt6 == 6'd0);
            if (neg_r) begin
              state_nxt = ST_SIGN;
            end else if (cnt6 == 6'd0) begin
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_RD;
            end
          end
        end else begin
          rem_nxt   = step[11:8];
          chunk_nxt = chunk_r + CH_W'(1);
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          oval_nxt  = 1'b1;
          ochar_nxt = CHAR_MINUS;
          olast_nxt = 1'b0;
          state_nxt = none_r ? ST_IDLE : ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          oval_nxt  = 1'b1;
          ochar_nxt = alpha_char(cfg.alphabet, rdata_r);
          olast_nxt = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r - IDX_W'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      oval_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
      cnt_r   <= cnt_nxt;
    end
    w_r     <= w_nxt;
    rem_r   <= rem_nxt;
    chunk_r <= chunk_nxt;
    neg_r   <= neg_nxt;
    none_r  <= none_nxt;
    idx_r   <= idx_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  // digit store, least significant digit at entry zero
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[cnt_r[IDX_W-1:0]] <= step[11:8];
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= store_mem[idx_r];
  end

  assign out_valid = oval_r;
  assign out_char  = ochar_r;
  assign out_last  = olast_r;

endmodule

### rtl/signed_integer_to_base_digits.sv
// ----------------------------------------------------------------------------
// signed_integer_to_base_digits: signed integer to radix text
// Converts one signed value to its characters in the configured alphabet:
// '-' for negative values, then the digits most significant first.
//
//   port group | direction | handshake          | payload
//   in_        | input     | in_valid/in_ready  | in_value
//   out_       | output    | out_valid/out_ready| out_char_out, out_last_char
//   cfg_       | input     | cfg_we             | cfg_idx, cfg_wdata
//
// Each digit is divided out in the shared divider one byte of the magnitude
// at a time, and each digit character passes through the digit store read
// port before it is sent. A two-entry queue lets intake run ahead.
// Reset is synchronous; it empties the queue and the output register.
// Intake pauses for the write cycle and the one after it; an unusable
// alphabet consumes beats without producing any character.
// ----------------------------------------------------------------------------
module signed_integer_to_base_digits
  import sitbd_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_char_out,
  output logic                  out_last_char,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_idx,
  input  logic [63:0]           cfg_wdata
);

  cfg_t                cfg;
  logic                push_valid;
  logic                push_ready;
  logic [VALUE_BITS:0] push_data;
  logic                q_valid;
  logic                q_ready;
  logic [VALUE_BITS:0] q_data;

  sitbd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sitbd_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sitbd_fifo #(.WIDTH(VALUE_BITS + 1)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  sitbd_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char_out),
    .out_last  (out_last_char)
  );

endmodule

### rtl/sitbd_checker.sv
// ----------------------------------------------------------------------------
// sitbd_checker: port-level checks for the radix text converter
// ----------------------------------------------------------------------------
module sitbd_checker
  import sitbd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char_out,
  input logic       out_last_char,
  input logic       cfg_we
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_out) && $stable(out_last_char))
    else $error("output beat changed while stalled");

  // the closing character is always a digit
  a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_char |-> out_char_out != CHAR_MINUS)
    else $error("last character is a minus sign");

  // a usable alphabet holds no zero byte
  a_no_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_char_out != 8'h00)
    else $error("zero byte sent");

  // intake pauses during and right after a register write
  a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !in_ready ##1 !in_ready)
    else $error("input taken while configuration settles");

endmodule

bind signed_integer_to_base_digits sitbd_checker u_sitbd_checker (.*);

### verif/radix_text_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix_text_checker: scoreboard for the signed integer to radix text block
// Watches the configuration port and both channels. It keeps its own copy
// of the radix and the digit alphabet, turns each accepted value into the
// characters it should produce, and compares every output beat, field by
// field, with the oldest character still owed.
// ----------------------------------------------------------------------------
module radix_text_checker
  import sitbd_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            out_char_out,
  input  logic                  out_last_char,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_idx,
  input  logic [63:0]           cfg_wdata,
  output int                    fail_count,
  output int                    chars_pending
);

  // owed characters: {char, last flag}
  logic [8:0]   owed_chars[$];
  logic [8:0]   owed;
  logic [4:0]   radix;
  logic [127:0] digit_set;

  // alphabet is usable when the radix fits and the characters in use are
  // nonzero, not a sign and all different
  function automatic bit alphabet_usable();
    logic [7:0] c;
    if (radix < 2 || radix > MAX_BASE) return 1'b0;
    for (int i = 0; i < radix; i++) begin
      c = digit_set[i*8 +: 8];
      if (c == 8'h00 || c == CHAR_PLUS || c == CHAR_MINUS) return 1'b0;
      for (int j = i + 1; j < radix; j++)
        if (digit_set[j*8 +: 8] == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // queue the text of one value: sign, then digits most significant first
  task automatic predict_text(input logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] mag;
    logic [3:0]            digits[VALUE_BITS];
    int                    n;
    if (!alphabet_usable()) return;
    mag = value[VALUE_BITS-1] ? -value : value;
    n = 0;
    do begin
      digits[n] = 4'(mag % radix);
      n++;
      mag = mag / radix;
    end while (mag != 0 && n < VALUE_BITS);
    if (value[VALUE_BITS-1]) owed_chars.push_back({CHAR_MINUS, 1'b0});
    for (int k = n - 1; k >= 0; k--)
      owed_chars.push_back({digit_set[{digits[k], 3'b000} +: 8], k == 0});
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      radix     = RST_BASE_SIZE;
      digit_set = {RST_ALPHA_HI, RST_ALPHA_LO};
      owed_chars.delete();
    end else begin
      // check the output beat against the oldest owed character
      if (out_valid && out_ready) begin
        if (owed_chars.size() == 0) begin
          fail_count++;
          $display("%0t: extra beat char=%h last=%b, expected none", $time,
                   out_char_out, out_last_char);
        end else begin
          owed = owed_chars.pop_front();
          if (out_char_out !== owed[8:1]) begin
            fail_count++;
            $display("%0t: char mismatch expected=%h actual=%h", $time,
                     owed[8:1], out_char_out);
          end
          if (out_last_char !== owed[0]) begin
            fail_count++;
            $display("%0t: last_char mismatch expected=%b actual=%b", $time,
                     owed[0], out_last_char);
          end
        end
      end
      // mirror register writes
      if (cfg_we) begin
        case (cfg_idx)
          REG_BASE_SIZE: radix = cfg_wdata[4:0];
          REG_ALPHA_LO:  digit_set[63:0] = cfg_wdata;
          REG_ALPHA_HI:  digit_set[127:64] = cfg_wdata;
          default: ;
        endcase
      end
      // predict the text of an accepted value
      if (in_valid && in_ready) predict_text(in_value);
    end
    chars_pending = owed_chars.size();
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level for the signed integer to radix text block
// Drives values and alphabet settings, stalls both channels in random
// bursts, and reports the verdict from the failure count of the checker.
// Directed values cover decimal, binary and hex extremes, ignored alphabet
// bytes and every way an alphabet can be unusable; random phases follow.
// ----------------------------------------------------------------------------
module testbench;
  import sitbd_pkg::*;

  localparam int          VALUE_BITS    = 32;
  localparam int          SETTLE_CYCLES = 400;
  localparam int          TEXT_VALUES   = 270;
  localparam int          QUIET_VALUES  = 60;
  localparam logic [63:0] HEX_HI        = 64'h6665_6463_6261_3938;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] in_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_char_out;
  logic                  out_last_char;
  logic                  cfg_we;
  logic [1:0]            cfg_idx;
  logic [63:0]           cfg_wdata;
  int                    fail_count;
  int                    chars_pending;
  int                    idle_level;
  int                    counted_values;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  signed_integer_to_base_digits #(.VALUE_BITS(VALUE_BITS)) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_out  (out_char_out),
    .out_last_char (out_last_char),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata)
  );

  radix_text_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_out  (out_char_out),
    .out_last_char (out_last_char),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .chars_pending (chars_pending)
  );

  // hard stop for a hung run
  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  // output side: accept, with stall bursts whose rate follows idle_level
  initial begin : char_sink
    int hold;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (idle_level > 0 && $urandom_range(0, 31) < idle_level * 2) begin
        hold = $urandom_range(1, 15);
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  // offer one value and hold it until the beat is taken; enter at negedge
  task automatic push_value(input logic [VALUE_BITS-1:0] value);
    int gap;
    if (idle_level > 0 && $urandom_range(0, 15) < idle_level * 2) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      in_value <= $urandom;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // drop valid, drain every owed character, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (chars_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write radix and alphabet while the block is idle
  task automatic load_alphabet(input logic [4:0] size, input logic [127:0] chars);
    logic [63:0] size_word;
    size_word      = {$urandom, $urandom};
    size_word[4:0] = size;
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_BASE_SIZE;
    cfg_wdata <= size_word;
    @(negedge clk);
    cfg_idx   <= REG_ALPHA_LO;
    cfg_wdata <= chars[63:0];
    @(negedge clk);
    cfg_idx   <= REG_ALPHA_HI;
    cfg_wdata <= chars[127:64];
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= {$urandom, $urandom};
  endtask

  // sixteen distinct characters, none of them zero or a sign
  function automatic logic [127:0] random_alphabet();
    logic [127:0] chars;
    bit           taken[256];
    logic [7:0]   c;
    for (int i = 0; i < MAX_BASE; i++) begin
      do c = 8'($urandom_range(1, 255));
      while (taken[c] || c == CHAR_PLUS || c == CHAR_MINUS);
      taken[c] = 1'b1;
      chars[i*8 +: 8] = c;
    end
    return chars;
  endfunction

  // break one character in use: zero, a sign, or a repeat
  function automatic logic [127:0] spoil_alphabet(input logic [127:0] chars,
                                                  input logic [4:0] size);
    int pos;
    int other;
    pos   = $urandom_range(0, size - 1);
    other = (pos + $urandom_range(1, size - 1)) % size;
    case ($urandom_range(0, 3))
      0:       chars[pos*8 +: 8] = 8'h00;
      1:       chars[pos*8 +: 8] = CHAR_PLUS;
      2:       chars[pos*8 +: 8] = CHAR_MINUS;
      default: chars[pos*8 +: 8] = chars[other*8 +: 8];
    endcase
    return chars;
  endfunction

  // mix of short texts, radix power boundaries, extremes and full range
  function automatic logic [VALUE_BITS-1:0] random_value(input logic [4:0] size);
    longint                p;
    int                    k;
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(0, 6))
      0: v = $urandom_range(0, int'(size) * int'(size));
      1: v = -$urandom_range(1, int'(size) * int'(size));
      2: v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                  : 32'h7fff_ffff - $urandom_range(0, 3);
      3: begin
        p = 1;
        k = $urandom_range(1, 31);
        for (int i = 0; i < k; i++)
          if (p * size <= 64'h8000_0000) p = p * size;
        v = VALUE_BITS'(p - $urandom_range(0, 1));
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin : stimulus
    logic [127:0] chars;
    logic [4:0]   size;
    bit           usable;
    int           phase_len;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_value       = '0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_BASE_SIZE;
    cfg_wdata      = '0;
    idle_level     = 0;
    counted_values = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    idle_level = 1;

    // decimal alphabet out of reset: zero, signs, digit count boundaries
    push_value(0);
    push_value(1);
    push_value(-1);
    push_value(9);
    push_value(-10);
    push_value(32'h7fff_ffff);
    push_value(32'h8000_0000);
    push_value(999_999_999);
    push_value(-1_000_000_000);

    // binary: longest texts
    load_alphabet(5'd2, {64'h0, 64'h3130});
    push_value(-1);
    push_value(32'h7fff_ffff);
    push_value(32'h8000_0000);

    // hex
    load_alphabet(5'd16, {HEX_HI, RST_ALPHA_LO});
    push_value(32'hdead_beef);
    push_value(15);
    push_value(32'h8000_0000);

    // radix 3 with signs, zeros and repeats in the ignored bytes
    load_alphabet(5'd3, {64'h3131_3131_0000_2B2D, 64'h2D2D_2B00_2D32_3331});
    push_value(-12345);
    push_value(200);

    // unusable alphabets: no text at all
    load_alphabet(5'd0, {RST_ALPHA_HI, RST_ALPHA_LO});
    push_value(7);
    load_alphabet(5'd1, {RST_ALPHA_HI, RST_ALPHA_LO});
    push_value(-7);
    load_alphabet(5'd17, {HEX_HI, RST_ALPHA_LO});
    push_value(123);
    load_alphabet(5'd10, {RST_ALPHA_HI, 64'h3736_3533_2B32_3130});
    push_value(42);
    load_alphabet(5'd10, {64'h2D38, RST_ALPHA_LO});
    push_value(-42);
    load_alphabet(5'd10, {RST_ALPHA_HI, 64'h3736_3534_3332_3100});
    push_value(5);
    load_alphabet(5'd16, {64'h3065_6463_6261_3938, RST_ALPHA_LO});
    push_value(32'hffff);

    // random phases, each with its own alphabet and idle rate
    while (counted_values < TEXT_VALUES) begin
      case ($urandom_range(0, 5))
        0:       size = 5'd2;
        1:       size = 5'd16;
        default: size = 5'($urandom_range(2, 16));
      endcase
      chars  = random_alphabet();
      usable = 1'b1;
      if ($urandom_range(0, 1))
        for (int i = size; i < MAX_BASE; i++) chars[i*8 +: 8] = 8'($urandom_range(0, 255));
      if (counted_values < TEXT_VALUES - QUIET_VALUES && $urandom_range(0, 5) == 0) begin
        usable = 1'b0;
        case ($urandom_range(0, 2))
          0:       size = 5'($urandom_range(0, 1));
          1:       size = 5'($urandom_range(17, 31));
          default: chars = spoil_alphabet(chars, size);
        endcase
      end
      // no idling at all toward the end
      idle_level = (counted_values >= TEXT_VALUES - QUIET_VALUES) ? 0 : $urandom_range(0, 3);
      load_alphabet(size, chars);
      phase_len = usable ? $urandom_range(15, 40) : $urandom_range(2, 6);
      repeat (phase_len) begin
        push_value(random_value(size));
        if (usable) counted_values++;
      end
    end

    settle();
    if (fail_count == 0 && chars_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
